>>> hw/rtl/gbcr_pkg.sv
// ============================================================================
// gbcr_pkg - gyro bias calibrate/remove shared definitions
// Register map codes, controller states and the command/status bundles that
// pass between the controller and the datapath.
// ============================================================================
package gbcr_pkg;

  // APB port geometry
  localparam int unsigned ADDR_BITS   = 4;
  localparam int unsigned DATA_BITS   = 32;

  // calib_count value after reset
  localparam int unsigned CALIB_RESET = 5000;

  // x, y, z
  localparam int unsigned NUM_AXES    = 3;

  // Register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_CALIB_COUNT = 2'd0,
    REG_BIAS_X      = 2'd1,
    REG_BIAS_Y      = 2'd2,
    REG_BIAS_Z      = 2'd3
  } reg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_WRITE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic write;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last_sample;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/gbcr_rate_if.sv
// ============================================================================
// gbcr_rate_if - gyro sample channel
// Valid/ready channel carrying one three-axis rate sample per request.
// ============================================================================
interface gbcr_rate_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] rate_x;
  logic signed [SAMPLE_BITS-1:0] rate_y;
  logic signed [SAMPLE_BITS-1:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

>>> hw/rtl/gbcr_corr_if.sv
// ============================================================================
// gbcr_corr_if - corrected rate channel
// Valid/ready channel carrying one bias-corrected sample per request.
// ============================================================================
interface gbcr_corr_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] corrected_x;
  logic signed [SAMPLE_BITS:0] corrected_y;
  logic signed [SAMPLE_BITS:0] corrected_z;
  logic                        ready_res;

  modport source (output valid, output corrected_x, output corrected_y, output corrected_z,
                  output ready_res, input ready);
  modport sink   (input valid, input corrected_x, input corrected_y, input corrected_z,
                  input ready_res, output ready);
endinterface

>>> hw/rtl/gbcr_regs.sv
// ============================================================================
// gbcr_regs - configuration register file
// APB-style write/read access to the calibration count and preset biases.
// ============================================================================
module gbcr_regs #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbcr_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [gbcr_pkg::DATA_BITS-1:0]    pwdata,
  output logic [gbcr_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready,
  output logic [COUNT_BITS-1:0]             calib_count,
  output logic signed [SAMPLE_BITS-1:0]     preset_bias_x,
  output logic signed [SAMPLE_BITS-1:0]     preset_bias_y,
  output logic signed [SAMPLE_BITS-1:0]     preset_bias_z
);
  import gbcr_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_count   <= COUNT_BITS'(CALIB_RESET);
      preset_bias_x <= '0;
      preset_bias_y <= '0;
      preset_bias_z <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_CALIB_COUNT: calib_count   <= pwdata[COUNT_BITS-1:0];
        REG_BIAS_X:      preset_bias_x <= $signed(pwdata[SAMPLE_BITS-1:0]);
        REG_BIAS_Y:      preset_bias_y <= $signed(pwdata[SAMPLE_BITS-1:0]);
        REG_BIAS_Z:      preset_bias_z <= $signed(pwdata[SAMPLE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CALIB_COUNT: prdata[COUNT_BITS-1:0]  = calib_count;
      REG_BIAS_X:      prdata[SAMPLE_BITS-1:0] = preset_bias_x;
      REG_BIAS_Y:      prdata[SAMPLE_BITS-1:0] = preset_bias_y;
      REG_BIAS_Z:      prdata[SAMPLE_BITS-1:0] = preset_bias_z;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/gbcr_ctrl.sv
// ============================================================================
// gbcr_ctrl - sequencing controller
// Accepts samples and, after the sample that completes calibration, runs the
// datapath divider through load, one quotient bit per step, and write-back.
// ============================================================================
module gbcr_ctrl #(
  parameter int STEPS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  gbcr_pkg::dp_status_t status,
  output logic                 in_ready,
  output gbcr_pkg::dp_cmd_t    cmd
);
  import gbcr_pkg::*;

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] step_cnt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step_cnt <= step_cnt + CW'(1);
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && status.last_sample) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (step_cnt == LAST_STEP) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = status.out_free;
        cmd.accept = status.out_free && in_valid;
      end
      ST_LOAD:  cmd.load  = 1'b1;
      ST_DIV:   cmd.step  = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/gbcr_datapath.sv
// ============================================================================
// gbcr_datapath - accumulate, divide and correct
// Per-axis accumulators, a radix-2 restoring divider per axis, bias
// subtraction with saturation, and the result output register.
// ============================================================================
module gbcr_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [COUNT_BITS-1:0]         calib_count,
  input  logic signed [SAMPLE_BITS-1:0] preset_bias_x,
  input  logic signed [SAMPLE_BITS-1:0] preset_bias_y,
  input  logic signed [SAMPLE_BITS-1:0] preset_bias_z,
  input  logic signed [SAMPLE_BITS-1:0] rate_x,
  input  logic signed [SAMPLE_BITS-1:0] rate_y,
  input  logic signed [SAMPLE_BITS-1:0] rate_z,
  input  gbcr_pkg::dp_cmd_t             cmd,
  output gbcr_pkg::dp_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS:0]   corrected_x,
  output logic signed [SAMPLE_BITS:0]   corrected_y,
  output logic signed [SAMPLE_BITS:0]   corrected_z,
  output logic                          ready_res
);
  import gbcr_pkg::*;

  localparam int AB = SAMPLE_BITS + COUNT_BITS;  // accumulator
  localparam int OB = SAMPLE_BITS + 1;           // result
  localparam int DB = AB + 1;                    // difference
  localparam logic signed [DB-1:0] LIMIT     = DB'((1 << SAMPLE_BITS) - 1);
  localparam logic signed [DB-1:0] NEG_LIMIT = -LIMIT;

  function automatic logic signed [OB-1:0] sat(input logic signed [DB-1:0] d);
    logic signed [OB-1:0] r;
    if (d > LIMIT) begin
      r = LIMIT[OB-1:0];
    end else if (d < NEG_LIMIT) begin
      r = NEG_LIMIT[OB-1:0];
    end else begin
      r = d[OB-1:0];
    end
    return r;
  endfunction

  logic signed [SAMPLE_BITS-1:0] smp     [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] pre     [NUM_AXES];
  logic [AB-1:0]                 acc     [NUM_AXES];
  logic [AB-1:0]                 acc_sum [NUM_AXES];
  logic [AB-1:0]                 quo     [NUM_AXES];
  logic [COUNT_BITS-1:0]         rem     [NUM_AXES];
  logic [COUNT_BITS-1:0]         rem_next[NUM_AXES];
  logic                          qbit    [NUM_AXES];
  logic                          neg     [NUM_AXES];
  logic [COUNT_BITS:0]           trial   [NUM_AXES];
  logic [COUNT_BITS:0]           trial_sub[NUM_AXES];
  logic signed [DB-1:0]          diff    [NUM_AXES];
  logic signed [OB-1:0]          res     [NUM_AXES];
  logic [COUNT_BITS-1:0]         seen;
  logic                          preset_mode;
  logic                          calibrating;

  assign smp[0] = rate_x;
  assign smp[1] = rate_y;
  assign smp[2] = rate_z;
  assign pre[0] = preset_bias_x;
  assign pre[1] = preset_bias_y;
  assign pre[2] = preset_bias_z;

  assign preset_mode        = (calib_count == '0);
  assign calibrating        = !preset_mode && (seen < calib_count);
  assign status.last_sample = calibrating && ((seen + COUNT_BITS'(1)) == calib_count);
  assign status.out_free    = !out_valid || out_ready;

  // Per-axis correction, accumulation and divider step
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      acc_sum[i] = acc[i] + {{COUNT_BITS{smp[i][SAMPLE_BITS-1]}}, smp[i]};
      if (preset_mode) begin
        diff[i] = {{(DB-SAMPLE_BITS){smp[i][SAMPLE_BITS-1]}}, smp[i]}
                - {{(DB-SAMPLE_BITS){pre[i][SAMPLE_BITS-1]}}, pre[i]};
      end else begin
        diff[i] = {{(DB-SAMPLE_BITS){smp[i][SAMPLE_BITS-1]}}, smp[i]}
                - {acc[i][AB-1], acc[i]};
      end
      if (calibrating) begin
        res[i] = {smp[i][SAMPLE_BITS-1], smp[i]};
      end else begin
        res[i] = sat(diff[i]);
      end
      trial[i]     = {rem[i], quo[i][AB-1]};
      trial_sub[i] = trial[i] - {1'b0, calib_count};
      qbit[i]      = (trial[i] >= {1'b0, calib_count});
      rem_next[i]  = qbit[i] ? trial_sub[i][COUNT_BITS-1:0] : trial[i][COUNT_BITS-1:0];
    end
  end

  // Sample count and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        acc[i] <= '0;
      end
    end else if (cmd.accept && calibrating) begin
      seen <= seen + COUNT_BITS'(1);
      for (int i = 0; i < NUM_AXES; i++) begin
        acc[i] <= acc_sum[i];
      end
    end else if (cmd.write) begin
      // apply the sign back to the quotient magnitude
      for (int i = 0; i < NUM_AXES; i++) begin
        acc[i] <= neg[i] ? (~quo[i] + AB'(1)) : quo[i];
      end
    end
  end

  // Divider: load magnitude, then shift one quotient bit per step
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (cmd.load) begin
        neg[i] <= acc[i][AB-1];
        quo[i] <= acc[i][AB-1] ? (~acc[i] + AB'(1)) : acc[i];
        rem[i] <= '0;
      end else if (cmd.step) begin
        quo[i] <= {quo[i][AB-2:0], qbit[i]};
        rem[i] <= rem_next[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      corrected_x <= res[0];
      corrected_y <= res[1];
      corrected_z <= res[2];
      ready_res   <= !calibrating;
    end
  end

endmodule

>>> hw/rtl/gyro_bias_calibrate_remove_top.sv
// ============================================================================
// gyro_bias_calibrate_remove_top - gyro zero-offset calibration and removal
// Averages the first calib_count samples into a per-axis bias, then
// subtracts it from every later sample; preset biases when the count is zero.
// ============================================================================
// A result is registered and presented in the cycle after its sample is accepted.
// One sample is taken per cycle while the result register is free and no divide runs.
// The sample that completes calibration starts a radix-2 divide of
// SAMPLE_BITS+COUNT_BITS steps; input is held off through the load, divide and
// write-back states and resumes when the controller returns to idle.
// Reset clears the sample count and accumulators and loads register defaults.
module gyro_bias_calibrate_remove_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  gbcr_rate_if.sink                      gyro,
  gbcr_corr_if.source                    corr,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gbcr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [gbcr_pkg::DATA_BITS-1:0] pwdata,
  output logic [gbcr_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import gbcr_pkg::*;

  logic [COUNT_BITS-1:0]         calib_count;
  logic signed [SAMPLE_BITS-1:0] preset_bias_x;
  logic signed [SAMPLE_BITS-1:0] preset_bias_y;
  logic signed [SAMPLE_BITS-1:0] preset_bias_z;
  dp_cmd_t                       dp_cmd;
  dp_status_t                    dp_status;
  logic                          in_ready;

  gbcr_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .calib_count   (calib_count),
    .preset_bias_x (preset_bias_x),
    .preset_bias_y (preset_bias_y),
    .preset_bias_z (preset_bias_z)
  );

  gbcr_ctrl #(
    .STEPS (SAMPLE_BITS + COUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (gyro.valid),
    .status   (dp_status),
    .in_ready (in_ready),
    .cmd      (dp_cmd)
  );

  gbcr_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .calib_count   (calib_count),
    .preset_bias_x (preset_bias_x),
    .preset_bias_y (preset_bias_y),
    .preset_bias_z (preset_bias_z),
    .rate_x        (gyro.rate_x),
    .rate_y        (gyro.rate_y),
    .rate_z        (gyro.rate_z),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .out_ready     (corr.ready),
    .out_valid     (corr.valid),
    .corrected_x   (corr.corrected_x),
    .corrected_y   (corr.corrected_y),
    .corrected_z   (corr.corrected_z),
    .ready_res     (corr.ready_res)
  );

  assign gyro.ready = in_ready;

  // Hold off input while the divider runs after the final calibration sample
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (gyro.valid && gyro.ready && dp_status.last_sample) |=> !gyro.ready)
    else $error("sample accepted while bias divide pending");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (gyro.valid && gyro.ready) |-> (!corr.valid || corr.ready))
    else $error("sample accepted over pending result");

  // Preset mode always yields a corrected result next cycle
  a_preset_ready: assert property (@(posedge clk) disable iff (rst)
    (gyro.valid && gyro.ready && calib_count == '0) |=> (corr.valid && corr.ready_res))
    else $error("preset mode result not flagged ready");

  // Every accepted sample produces a presented result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (gyro.valid && gyro.ready) |=> corr.valid)
    else $error("accepted sample produced no result");

endmodule

>>> dv/tb_gyro_bias_calibrate_remove_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_gyro_bias_calibrate_remove_top - gyro bias calibrate/remove testbench
// Drives three-axis gyro samples and APB register writes into the block and
// checks every corrected sample against a typed table value or an in-bench model
// of the calibration counter, the per-axis accumulators and the bias subtraction.
// A directed table covers reset defaults, extremes, saturation and count changes;
// random phases of calibration, preset bias and lowered-count runs follow.
// ============================================================================
module tb_gyro_bias_calibrate_remove_top;
  import gbcr_pkg::*;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int DIV_SETTLE    = SAMPLE_BITS + COUNT_BITS + 8;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int PLAN_ROWS     = 28;

  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;
  typedef enum logic [1:0] { RX_ALWAYS, RX_PATTERN, RX_RANDOM } rx_mode_t;

  // One corrected sample: axis[0..2] = x, y, z
  typedef struct packed {
    logic [2:0][SAMPLE_BITS:0] axis;
    logic                      applied;
  } corr_t;

  typedef struct {
    row_kind_t kind;
    reg_idx_t  idx;
    int        wval;
    int        rx, ry, rz;
    bit        typed;
    int        ex, ey, ez;
    bit        er;
  } plan_row_t;

  // Directed stimulus; typed results only where they are obvious
  plan_row_t plan [PLAN_ROWS] = '{
    // calibration after reset: raw pass-through, partial sums build up
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,  32767, -32768,      0, 1'b1,  32767, -32768,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,     -1,      1,  12345, 1'b1,     -1,      1,  12345, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,  32767, -32768, -12345, 1'b1,  32767, -32768, -12345, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,  32767, -32768,      0, 1'b1,  32767, -32768,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0, -21846,  21845,     -1, 1'b1, -21846,  21845,     -1, 1'b0},
    // count lowered under the samples seen: partial sum is the bias, saturates
    '{ROW_WRITE,  REG_CALIB_COUNT, 1,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0, -32768,  32767,      5, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    // preset biases at the extremes
    '{ROW_WRITE,  REG_CALIB_COUNT, 0,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_WRITE,  REG_BIAS_X, -32768,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_WRITE,  REG_BIAS_Y,  32767,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_WRITE,  REG_BIAS_Z,      0,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,  32767, -32768, -32768, 1'b1,  65535, -65535, -32768, 1'b1},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,      0,      0,      0, 1'b1,  32768, -32767,      0, 1'b1},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0, -32768,  32767,  32767, 1'b1,      0,      0,  32767, 1'b1},
    '{ROW_WRITE,  REG_BIAS_X,      0,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_WRITE,  REG_BIAS_Y,      0,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_WRITE,  REG_BIAS_Z,     -1,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,    100,   -100,      0, 1'b1,    100,   -100,      1, 1'b1},
    // count raised after calibration: accumulate on top of the old bias
    '{ROW_WRITE,  REG_CALIB_COUNT, 7,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,   1000,  -1000,      3, 1'b1,   1000,  -1000,      3, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,   2000,  -2000,     -3, 1'b1,   2000,  -2000,     -3, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    // full-scale count, then a count reachable with one more sample
    '{ROW_WRITE,  REG_CALIB_COUNT, 65535,  0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,     -7,      7,      1, 1'b1,     -7,      7,      1, 1'b0},
    '{ROW_WRITE,  REG_CALIB_COUNT, 9,      0,      0,      0, 1'b0,      0,      0,      0, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,     -3,     -3,     -3, 1'b1,     -3,     -3,     -3, 1'b0},
    '{ROW_SAMPLE, REG_CALIB_COUNT, 0,      5,      5,      5, 1'b0,      0,      0,      0, 1'b0}
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  gbcr_rate_if #(.SAMPLE_BITS(SAMPLE_BITS)) gyro_ch ();
  gbcr_corr_if #(.SAMPLE_BITS(SAMPLE_BITS)) corr_ch ();

  gyro_bias_calibrate_remove_top #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .gyro    (gyro_ch),
    .corr    (corr_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model of the block's registers and calibration state
  logic [COUNT_BITS-1:0]                    cal_count_m;
  logic signed [SAMPLE_BITS-1:0]            preset_m [3];
  logic [COUNT_BITS-1:0]                    seen_m;
  logic signed [SAMPLE_BITS+COUNT_BITS-1:0] acc_m [3];

  corr_t    pending_corr [$];
  int       errors;
  int       samples_sent;
  int       results_checked;
  int       divisions;
  int       saturated;
  int       cfg_writes;
  int       cycle_count;
  int       burst_left;
  bit       gaps_on;
  bit       hold_req;
  rx_mode_t rx_mode;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Clamp a difference to the output range
  function automatic logic [SAMPLE_BITS:0] clamp_rate(input longint d);
    if (d > 65535) begin
      d = 65535;
      saturated++;
    end else if (d < -65535) begin
      d = -65535;
      saturated++;
    end
    return 17'(d);
  endfunction

  // Advance the calibration state by one sample and return its corrected value
  function automatic corr_t predict_correction(input logic signed [SAMPLE_BITS-1:0] rx,
                                               input logic signed [SAMPLE_BITS-1:0] ry,
                                               input logic signed [SAMPLE_BITS-1:0] rz);
    logic signed [SAMPLE_BITS-1:0] s [3];
    corr_t r;
    s[0] = rx;
    s[1] = ry;
    s[2] = rz;
    if (cal_count_m == 0) begin
      for (int i = 0; i < 3; i++)
        r.axis[i] = clamp_rate(longint'(s[i]) - longint'(preset_m[i]));
      r.applied = 1'b1;
    end else if (seen_m < cal_count_m) begin
      seen_m = seen_m + 1'b1;
      for (int i = 0; i < 3; i++)
        acc_m[i] = acc_m[i] + s[i];
      if (seen_m == cal_count_m) begin
        for (int i = 0; i < 3; i++)
          acc_m[i] = 32'(longint'(acc_m[i]) / longint'(cal_count_m));
        divisions++;
      end
      for (int i = 0; i < 3; i++)
        r.axis[i] = {s[i][SAMPLE_BITS-1], s[i]};
      r.applied = 1'b0;
    end else begin
      for (int i = 0; i < 3; i++)
        r.axis[i] = clamp_rate(longint'(s[i]) - longint'(acc_m[i]));
      r.applied = 1'b1;
    end
    return r;
  endfunction

  // Random rate: mostly near a center, some full-range, some extremes
  function automatic logic signed [SAMPLE_BITS-1:0] gen_rate(input int center);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      v = center + int'($urandom_range(0, 800)) - 400;
    end else if (pick < 85) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Hold until every result is back and any divide has finished
  task automatic wait_drain();
    while (pending_corr.size() != 0) @(posedge clk);
    repeat (DIV_SETTLE) @(posedge clk);
  endtask

  // Offer one sample in bursts with random gaps; record its expected result
  task automatic send_rate(input logic signed [SAMPLE_BITS-1:0] x,
                           input logic signed [SAMPLE_BITS-1:0] y,
                           input logic signed [SAMPLE_BITS-1:0] z,
                           input bit typed, input corr_t typed_val);
    corr_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gyro_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    gyro_ch.valid  <= 1'b1;
    gyro_ch.rate_x <= x;
    gyro_ch.rate_y <= y;
    gyro_ch.rate_z <= z;
    @(posedge clk);
    while (!gyro_ch.ready) @(posedge clk);
    p = predict_correction(x, y, z);
    pending_corr.push_back(typed ? typed_val : p);
    samples_sent++;
  endtask

  // Write a register while idle, read it back and update the model
  task automatic config_write(input reg_idx_t idx, input int val);
    logic [DATA_BITS-1:0] rd;
    gyro_ch.valid <= 1'b0;
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CALIB_COUNT: cal_count_m = val[COUNT_BITS-1:0];
      REG_BIAS_X:      preset_m[0] = val[SAMPLE_BITS-1:0];
      REG_BIAS_Y:      preset_m[1] = val[SAMPLE_BITS-1:0];
      default:         preset_m[2] = val[SAMPLE_BITS-1:0];
    endcase
    cfg_writes++;
    if (rd[15:0] !== val[15:0])
      report_mismatch($sformatf("register %s read %h, wrote %h", idx.name(), rd, val));
  endtask

  // Receiver: long hold-off once when asked, otherwise the current stall mode
  initial begin : receiver
    int rx_tick;
    int hold_cnt;
    bit hold_done;
    rx_tick   = 0;
    hold_cnt  = 0;
    hold_done = 1'b0;
    corr_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_req && !hold_done) begin
        corr_ch.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  corr_ch.ready <= 1'b1;
          RX_PATTERN: corr_ch.ready <= (rx_tick % 7 != 3) && (rx_tick % 11 != 5);
          default:    corr_ch.ready <= ($urandom_range(0, 99) < 65);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_corr
    corr_t                     want;
    logic [2:0][SAMPLE_BITS:0] got;
    string                     axn [3];
    axn = '{"x", "y", "z"};
    if (!rst && corr_ch.valid && corr_ch.ready) begin
      got = {corr_ch.corrected_z, corr_ch.corrected_y, corr_ch.corrected_x};
      if (pending_corr.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %0d %0d %0d ready_res=%0b",
                                  $signed(got[0]), $signed(got[1]), $signed(got[2]),
                                  corr_ch.ready_res));
      end else begin
        want = pending_corr.pop_front();
        results_checked++;
        for (int i = 0; i < 3; i++)
          if (got[i] !== want.axis[i])
            report_mismatch($sformatf("corrected_%s got %0d want %0d", axn[i],
                                      $signed(got[i]), $signed(want.axis[i])));
        if (corr_ch.ready_res !== want.applied)
          report_mismatch($sformatf("ready_res got %b want %b", corr_ch.ready_res,
                                    want.applied));
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_corr.size());
      $display("tb_gyro_bias_calibrate_remove_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    corr_t want;
    int    center;
    int    pick;
    int    k;
    int    m;
    int    n;
    int    phase_no;
    int    target;
    int    w;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    gyro_ch.valid  <= 1'b0;
    gyro_ch.rate_x <= '0;
    gyro_ch.rate_y <= '0;
    gyro_ch.rate_z <= '0;
    errors          = 0;
    samples_sent    = 0;
    results_checked = 0;
    divisions       = 0;
    saturated       = 0;
    cfg_writes      = 0;
    cycle_count     = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_req        = 1'b0;
    rx_mode         = RX_RANDOM;
    phase_no        = 0;
    cal_count_m     = COUNT_BITS'(CALIB_RESET);
    seen_m          = '0;
    for (int i = 0; i < 3; i++) begin
      preset_m[i] = '0;
      acc_m[i]    = '0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        config_write(plan[i].idx, plan[i].wval);
      end else begin
        want.axis[0] = 17'(plan[i].ex);
        want.axis[1] = 17'(plan[i].ey);
        want.axis[2] = 17'(plan[i].ez);
        want.applied = plan[i].er;
        send_rate(SAMPLE_BITS'(plan[i].rx), SAMPLE_BITS'(plan[i].ry),
                  SAMPLE_BITS'(plan[i].rz), plan[i].typed, want);
      end
    end

    // Random phases: calibrate, preset biases, or lowered count mid-calibration
    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target) begin
      center  = int'($urandom_range(0, 6000)) - 3000;
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 50 && seen_m < 65000) begin
        k = $urandom_range(1, 8);
        config_write(REG_CALIB_COUNT, int'(seen_m) + k);
        n = k + $urandom_range(4, 24);
      end else if (pick < 75) begin
        config_write(REG_CALIB_COUNT, 0);
        config_write(REG_BIAS_X, int'(gen_rate(center)));
        config_write(REG_BIAS_Y, int'(gen_rate(center)));
        config_write(REG_BIAS_Z, int'(gen_rate(center)));
        n = $urandom_range(8, 30);
      end else begin
        config_write(REG_CALIB_COUNT,
                     ($urandom_range(0, 1) != 0) ? 65535 : int'(seen_m) + 60);
        m = $urandom_range(1, 5);
        repeat (m) send_rate(gen_rate(center), gen_rate(center), gen_rate(center), 1'b0, '0);
        config_write(REG_CALIB_COUNT, $urandom_range(1, seen_m));
        n = $urandom_range(6, 20);
      end
      // back the block up once: receiver holds off while samples keep coming
      if (phase_no == 0) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      repeat (n) send_rate(gen_rate(center), gen_rate(center), gen_rate(center), 1'b0, '0);
      phase_no++;
    end

    // Drain with a bound, then let any divide finish
    gyro_ch.valid <= 1'b0;
    rx_mode = RX_ALWAYS;
    for (w = 0; w < DRAIN_LIMIT && pending_corr.size() != 0; w++) @(posedge clk);
    repeat (DIV_SETTLE) @(posedge clk);
    if (pending_corr.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_corr.size()));

    $display("run: %0d samples in %0d random phases, %0d results checked, %0d register writes",
             samples_sent, phase_no, results_checked, cfg_writes);
    $display("run: %0d bias divisions, %0d saturated axis values, %0d mismatches",
             divisions, saturated, errors);
    if (errors == 0) begin
      $display("tb_gyro_bias_calibrate_remove_top: PASS");
    end else begin
      $display("tb_gyro_bias_calibrate_remove_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gbcr_pkg.sv
hw/rtl/gbcr_rate_if.sv
hw/rtl/gbcr_corr_if.sv
hw/rtl/gbcr_regs.sv
hw/rtl/gbcr_ctrl.sv
hw/rtl/gbcr_datapath.sv
hw/rtl/gyro_bias_calibrate_remove_top.sv
dv/tb_gyro_bias_calibrate_remove_top.sv
